### rtl/cbuh_pkg.sv
// Shared constants, types and helpers for the complex byte unpack histogram block.
package cbuh_pkg;

  // Histogram geometry
  localparam int NUM_POLS   = 2;
  localparam int NUM_BINS   = 256;
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int COUNT_BITS = 32;

  // Field widths
  localparam int SMP_W   = 8;
  localparam int SCALE_W = 16;
  localparam int PROD_W  = 24;
  localparam int BCNT_W  = 32;

  // Output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef logic [COUNT_BITS-1:0]     count_t;
  typedef logic signed [SMP_W-1:0]   smp_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [SCALE_W-1:0]        scale_t;
  typedef logic [BIN_W-1:0]          bin_t;
  typedef logic [BCNT_W-1:0]         bcnt_t;

  localparam count_t COUNT_MAX    = '1;
  localparam scale_t SCALE_RESET  = 16'd4096;
  localparam smp_t   SMP_MOST_NEG = 8'sh80;

  // Word kinds
  localparam logic FUNC_UNPACK = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  // Clear sweep control from top to lanes
  typedef struct packed {
    logic act;
    bin_t idx;
  } clr_t;

  // One lane's share of an accepted word
  typedef struct packed {
    logic vld;
    logic func;
    logic pol;
    bin_t bin_index;
    smp_t smp;
  } lane_req_t;

  // What a lane found, in the cycle after acceptance
  typedef struct packed {
    logic   vld;
    logic   func;
    prod_t  prod;
    count_t cnt;
  } lane_rsp_t;

  // Result word
  typedef struct packed {
    prod_t re;
    prod_t im;
    bcnt_t cnt;
  } out_word_t;

  // Low bits of a count, zero-extended when the count is narrow
  function automatic bcnt_t to_bin_count(input count_t c);
    logic [COUNT_BITS+BCNT_W-1:0] w;
    w = (COUNT_BITS + BCNT_W)'(c);
    return w[BCNT_W-1:0];
  endfunction

endpackage

### rtl/cbuh_if.sv
// Valid/ready channel interfaces for sample/read words and result words.
interface cbuh_in_if;
  logic                valid;
  logic                ready;
  logic                func;
  logic                pol;
  cbuh_pkg::smp_t      re_sample;
  cbuh_pkg::smp_t      im_sample;
  cbuh_pkg::bin_t      bin_index;

  modport source (output valid, func, pol, re_sample, im_sample, bin_index, input ready);
  modport sink   (input valid, func, pol, re_sample, im_sample, bin_index, output ready);
endinterface

interface cbuh_out_if;
  logic                valid;
  logic                ready;
  cbuh_pkg::prod_t     re_out;
  cbuh_pkg::prod_t     im_out;
  cbuh_pkg::bcnt_t     bin_count;

  modport source (output valid, re_out, im_out, bin_count, input ready);
  modport sink   (input valid, re_out, im_out, bin_count, output ready);
endinterface

### rtl/complex_byte_unpack_histogram_core.sv
// Top level: int8 complex sample unpack with per-polarization level histograms.
//
// Input channel in_ch carries one word per handshake: an unpack word (func 0)
// with a real/imaginary int8 pair, or a read word (func 1) naming one bin of
// one polarization's histogram. Output channel out_ch returns exactly one
// result word per input word, in order: scaled values for unpack words,
// the bin count for read words. cfg_we/cfg_wdata write the Q4.12 scale.
//
// Throughput: one word per cycle while the output queue has room. The real
// and imaginary parts go to two lanes, each with its own count memory per
// polarization, so each lane does one read-modify-write per cycle; a read
// sums the two lanes' counts. A result passes the lane and merge registers and
// the output queue before it is offered.
//
// Reset: synchronous, active low. Afterwards a clear pass zeroes all 256 bins
// of the histograms, one bin of every memory per cycle, and in_ch.ready stays
// low until it ends; configuration writes are taken throughout.
// Receiver stall: a 4-word output queue absorbs results; in_ch.ready drops
// only once queued plus in-flight words would fill it.
module complex_byte_unpack_histogram_core (
  input  logic               clk,
  input  logic               rst_n,
  cbuh_in_if.sink            in_ch,
  cbuh_out_if.source         out_ch,
  input  logic               cfg_we,
  input  cbuh_pkg::scale_t   cfg_wdata
);

  cbuh_pkg::scale_t     scale_r;
  logic                 clr_act_r;
  cbuh_pkg::bin_t       clr_idx_r;
  cbuh_pkg::clr_t       clr;
  logic                 can_take;
  logic                 in_acc;
  cbuh_pkg::lane_req_t  req_re;
  cbuh_pkg::lane_req_t  req_im;
  cbuh_pkg::lane_rsp_t  rsp_re;
  cbuh_pkg::lane_rsp_t  rsp_im;

  // Scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= cbuh_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  // Clear sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_act_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == cbuh_pkg::BIN_W'(cbuh_pkg::NUM_BINS - 1)) begin
        clr_act_r <= 1'b0;
      end
    end
  end

  assign clr.act = clr_act_r;
  assign clr.idx = clr_idx_r;

  // Input handshake
  assign in_ch.ready = can_take && !clr_act_r;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Split the word across the lanes
  always_comb begin
    req_re.vld       = in_acc;
    req_re.func      = in_ch.func;
    req_re.pol       = in_ch.pol;
    req_re.bin_index = in_ch.bin_index;
    req_re.smp       = in_ch.re_sample;
    req_im           = req_re;
    req_im.smp       = in_ch.im_sample;
  end

  cbuh_lane u_lane_re (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (clr),
    .scale (scale_r),
    .req   (req_re),
    .rsp   (rsp_re)
  );

  cbuh_lane u_lane_im (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (clr),
    .scale (scale_r),
    .req   (req_im),
    .rsp   (rsp_im)
  );

  cbuh_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .rsp_re   (rsp_re),
    .rsp_im   (rsp_im),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_act_r |-> !in_ch.ready)
    else $error("word accepted during clear sweep");

endmodule

### rtl/cbuh_lane.sv
// One sample lane: zero fix-up, scaling multiply and a banked histogram update.
module cbuh_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  cbuh_pkg::clr_t      clr,
  input  cbuh_pkg::scale_t    scale,
  input  cbuh_pkg::lane_req_t req,
  output cbuh_pkg::lane_rsp_t rsp
);

  cbuh_pkg::smp_t         smp_z;
  cbuh_pkg::bin_t         upd_bin;
  cbuh_pkg::bin_t         rd_bin;
  logic                   pol_ok;
  logic signed [cbuh_pkg::PROD_W:0] prod_full;

  logic                   s1_vld_r;
  logic                   s1_func_r;
  logic                   s1_pol_r;
  logic                   s1_pol_ok_r;
  cbuh_pkg::bin_t         s1_bin_r;
  cbuh_pkg::prod_t        prod_r;
  logic                   fwd_hit_r;
  logic                   fwd_hit_nxt;
  cbuh_pkg::count_t       fwd_cnt_r;

  cbuh_pkg::count_t       bank_rd_r [cbuh_pkg::NUM_POLS];
  cbuh_pkg::count_t       cur_mem;
  cbuh_pkg::count_t       cur;
  cbuh_pkg::count_t       cnt_inc;
  logic                   s1_wr;

  // Accept stage: most negative code reads as zero, bin = value + 128
  always_comb begin
    smp_z     = (req.smp == cbuh_pkg::SMP_MOST_NEG) ? '0 : req.smp;
    upd_bin   = {~smp_z[cbuh_pkg::SMP_W-1], smp_z[cbuh_pkg::SMP_W-2:0]};
    rd_bin    = (req.func == cbuh_pkg::FUNC_READ) ? req.bin_index : upd_bin;
    pol_ok    = (32'(req.pol) < cbuh_pkg::NUM_POLS);
    prod_full = (cbuh_pkg::PROD_W + 1)'(smp_z) *
                (cbuh_pkg::PROD_W + 1)'(signed'({1'b0, scale}));
  end

  // Update stage: write-back of the bumped count
  assign s1_wr = s1_vld_r && (s1_func_r == cbuh_pkg::FUNC_UNPACK) && s1_pol_ok_r;

  // Same bin written last cycle: take the fresh count, not the stale read
  assign fwd_hit_nxt = s1_wr && (s1_bin_r == rd_bin) && (s1_pol_r == req.pol);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      s1_vld_r  <= req.vld;
      fwd_hit_r <= fwd_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_func_r   <= req.func;
    s1_pol_r    <= req.pol;
    s1_pol_ok_r <= pol_ok;
    s1_bin_r    <= rd_bin;
    prod_r      <= (req.func == cbuh_pkg::FUNC_READ) ? '0 : prod_full[cbuh_pkg::PROD_W-1:0];
    fwd_cnt_r   <= cnt_inc;
  end

  // One count memory per polarization; the clear sweep zeroes all banks at once
  for (genvar p = 0; p < cbuh_pkg::NUM_POLS; p++) begin : g_bank
    cbuh_pkg::count_t mem [cbuh_pkg::NUM_BINS];
    logic             we;
    cbuh_pkg::bin_t   waddr;
    cbuh_pkg::count_t wdata;

    always_comb begin
      we    = clr.act || (s1_wr && (32'(s1_pol_r) == p));
      waddr = clr.act ? clr.idx : s1_bin_r;
      wdata = clr.act ? '0 : cnt_inc;
    end

    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      bank_rd_r[p] <= mem[rd_bin];
    end
  end

  // Bank select and saturating bump
  always_comb begin
    cur_mem = '0;
    for (int p = 0; p < cbuh_pkg::NUM_POLS; p++) begin
      if (32'(s1_pol_r) == p) begin
        cur_mem = bank_rd_r[p];
      end
    end
    cur     = fwd_hit_r ? fwd_cnt_r : cur_mem;
    cnt_inc = (cur == cbuh_pkg::COUNT_MAX) ? cur : cur + 1'b1;
  end

  always_comb begin
    rsp.vld  = s1_vld_r;
    rsp.func = s1_func_r;
    rsp.prod = prod_r;
    rsp.cnt  = ((s1_func_r == cbuh_pkg::FUNC_READ) && s1_pol_ok_r) ? cur : '0;
  end

  a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> $past(s1_wr))
    else $error("forward hit without a write in the previous cycle");

  a_no_update_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr.act |-> !s1_wr)
    else $error("histogram update during clear sweep");

endmodule

### rtl/cbuh_merge.sv
// Merge stage: sums the lanes' partial counts and queues result words.
module cbuh_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  cbuh_pkg::lane_rsp_t rsp_re,
  input  cbuh_pkg::lane_rsp_t rsp_im,
  output logic                can_take,
  cbuh_out_if.source          out_ch
);

  logic [cbuh_pkg::COUNT_BITS:0] sum;
  cbuh_pkg::count_t              sat;

  logic                          s2_vld_r;
  cbuh_pkg::out_word_t           s2_word_r;

  cbuh_pkg::out_word_t           fifo_r [cbuh_pkg::FIFO_DEPTH];
  logic [cbuh_pkg::FIFO_AW-1:0]  wr_ptr_r;
  logic [cbuh_pkg::FIFO_AW-1:0]  rd_ptr_r;
  logic [cbuh_pkg::FIFO_CW-1:0]  cnt_r;
  logic [cbuh_pkg::FIFO_CW-1:0]  cnt_nxt;
  logic [cbuh_pkg::FIFO_CW-1:0]  occ;
  logic                          push;
  logic                          pop;

  // Each lane saw one of the two parts; the true count is the clamped sum
  always_comb begin
    sum = {1'b0, rsp_re.cnt} + {1'b0, rsp_im.cnt};
    sat = sum[cbuh_pkg::COUNT_BITS] ? cbuh_pkg::COUNT_MAX : sum[cbuh_pkg::COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= rsp_re.vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_word_r.re  <= rsp_re.prod;
    s2_word_r.im  <= rsp_im.prod;
    s2_word_r.cnt <= cbuh_pkg::to_bin_count(sat);
  end

  // Output queue
  assign push    = s2_vld_r;
  assign pop     = out_ch.valid && out_ch.ready;
  assign cnt_nxt = cnt_r + cbuh_pkg::FIFO_CW'(push) - cbuh_pkg::FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= s2_word_r;
    end
  end

  // Credit: queued words plus those still in the pipe must leave room
  assign occ      = cnt_r + cbuh_pkg::FIFO_CW'(s2_vld_r) + cbuh_pkg::FIFO_CW'(rsp_re.vld);
  assign can_take = (occ < cbuh_pkg::FIFO_CW'(cbuh_pkg::FIFO_DEPTH));

  always_comb begin
    out_ch.valid     = (cnt_r != '0);
    out_ch.re_out    = fifo_r[rd_ptr_r].re;
    out_ch.im_out    = fifo_r[rd_ptr_r].im;
    out_ch.bin_count = fifo_r[rd_ptr_r].cnt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cbuh_pkg::FIFO_CW'(cbuh_pkg::FIFO_DEPTH))
    else $error("output queue count past depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < cbuh_pkg::FIFO_CW'(cbuh_pkg::FIFO_DEPTH)) || pop)
    else $error("push into full output queue");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_re.vld == rsp_im.vld)
    else $error("lane responses out of step");

endmodule

### test/tb_complex_byte_unpack_histogram_core.sv
// Testbench for the complex byte unpack histogram core: directed table, random words, scoreboard.
module tb_complex_byte_unpack_histogram_core;
  import cbuh_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 4;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_WORDS  = 325;
  localparam int DIR_ROWS     = 19;

  // One input word as the sender sees it
  typedef struct packed {
    logic func;
    logic pol;
    smp_t re;
    smp_t im;
    bin_t bin;
  } sample_word_t;

  // Directed row: the word, plus a hand-written result where it is obvious
  typedef struct packed {
    sample_word_t word;
    logic         typed;
    out_word_t    res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  scale_t cfg_wdata;

  cbuh_in_if  in_ch();
  cbuh_out_if out_ch();

  complex_byte_unpack_histogram_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: scale register and both level histograms
  scale_t    scale_reg;
  count_t    level_hist [NUM_POLS][NUM_BINS];
  out_word_t pending_results [$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        send_no_idle = 1'b0;
  stim_row_t dir_rows [DIR_ROWS];

  function automatic void bump_bin(input logic pol, input smp_t v);
    bin_t b;
    b = bin_t'(int'(v) + NUM_BINS / 2);
    if (level_hist[pol][b] != COUNT_MAX) begin
      level_hist[pol][b] = level_hist[pol][b] + 1'b1;
    end
  endfunction

  // Scaled pair plus histogram update, or a bin read
  function automatic out_word_t unpack_and_count(input sample_word_t w);
    out_word_t r;
    smp_t re_v;
    smp_t im_v;
    r = '0;
    if (w.func == FUNC_READ) begin
      r.cnt = bcnt_t'(level_hist[w.pol][w.bin]);
      return r;
    end
    // most negative code counts as zero
    re_v = (w.re == SMP_MOST_NEG) ? smp_t'(0) : w.re;
    im_v = (w.im == SMP_MOST_NEG) ? smp_t'(0) : w.im;
    r.re = prod_t'(int'(re_v) * int'(scale_reg));
    r.im = prod_t'(int'(im_v) * int'(scale_reg));
    bump_bin(w.pol, re_v);
    bump_bin(w.pol, im_v);
    return r;
  endfunction

  function automatic stim_row_t row(input logic func, input logic pol, input smp_t re,
                                    input smp_t im, input bin_t bin, input logic typed,
                                    input prod_t re_x, input prod_t im_x, input bcnt_t cnt_x);
    stim_row_t s;
    s.word  = '{func: func, pol: pol, re: re, im: im, bin: bin};
    s.typed = typed;
    s.res   = '{re: re_x, im: im_x, cnt: cnt_x};
    return s;
  endfunction

  function automatic smp_t draw_sample();
    case ($urandom_range(0, 7))
      0: return SMP_MOST_NEG;
      1: return smp_t'(127);
      2: return smp_t'(-127);
      default: return smp_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic sample_word_t draw_word();
    sample_word_t w;
    w.func = ($urandom_range(0, 4) == 0) ? FUNC_READ : FUNC_UNPACK;
    w.pol  = 1'($urandom_range(0, 1));
    w.re   = draw_sample();
    w.im   = draw_sample();
    w.bin  = ($urandom_range(0, 3) == 0) ? bin_t'(128) : bin_t'($urandom_range(0, 255));
    return w;
  endfunction

  // Offer one word after a random gap; predict once it is taken
  task automatic send_word(input sample_word_t w, input logic typed, input out_word_t typed_res);
    int gap;
    out_word_t res;
    gap = send_no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= w.func;
    in_ch.pol       <= w.pol;
    in_ch.re_sample <= w.re;
    in_ch.im_sample <= w.im;
    in_ch.bin_index <= w.bin;
    do @(posedge clk); while (!in_ch.ready);
    res = unpack_and_count(w);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // Stop sending and wait until every result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(input scale_t v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    scale_reg = v;
  endtask

  // Result checker
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result re %0d im %0d count %0d", $time,
                 out_ch.re_out, out_ch.im_out, out_ch.bin_count);
        mismatches++;
      end else begin
        exp_w = pending_results.pop_front();
        if (out_ch.re_out !== exp_w.re) begin
          $display("%0t: re_out expected %0d actual %0d", $time, exp_w.re, out_ch.re_out);
          mismatches++;
        end
        if (out_ch.im_out !== exp_w.im) begin
          $display("%0t: im_out expected %0d actual %0d", $time, exp_w.im, out_ch.im_out);
          mismatches++;
        end
        if (out_ch.bin_count !== exp_w.cnt) begin
          $display("%0t: bin_count expected %0d actual %0d", $time, exp_w.cnt,
                   out_ch.bin_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls, with stretches of none
  initial begin
    int stall;
    int taken;
    bit recv_no_idle;
    taken = 0;
    recv_no_idle = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      if (taken % 40 == 0) begin
        recv_no_idle = ($urandom_range(0, 2) == 0);
      end
      stall = recv_no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  // Sender and run control
  initial begin
    scale_t phase_scale;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FUNC_UNPACK;
    in_ch.pol       <= 1'b0;
    in_ch.re_sample <= '0;
    in_ch.im_sample <= '0;
    in_ch.bin_index <= '0;
    scale_reg = SCALE_RESET;
    foreach (level_hist[p, b]) level_hist[p][b] = '0;

    // directed words, reset scale of 1.0
    dir_rows[0]  = row(FUNC_READ,   1'b0,    0,    0,   0, 1'b1,       0,       0, 0);
    dir_rows[1]  = row(FUNC_READ,   1'b1,    0,    0, 255, 1'b1,       0,       0, 0);
    dir_rows[2]  = row(FUNC_READ,   1'b0,    0,    0, 128, 1'b1,       0,       0, 0);
    dir_rows[3]  = row(FUNC_UNPACK, 1'b0,  127, -127,   0, 1'b1,  520192, -520192, 0);
    dir_rows[4]  = row(FUNC_UNPACK, 1'b0, -128, -128, 255, 1'b1,       0,       0, 0);
    dir_rows[5]  = row(FUNC_READ,   1'b0,    0,    0, 128, 1'b1,       0,       0, 2);
    dir_rows[6]  = row(FUNC_UNPACK, 1'b1, -128,    5,   0, 1'b1,       0,   20480, 0);
    dir_rows[7]  = row(FUNC_UNPACK, 1'b1,    0, -128,   0, 1'b1,       0,       0, 0);
    dir_rows[8]  = row(FUNC_READ,   1'b1,  127, -128, 128, 1'b1,       0,       0, 3);
    dir_rows[9]  = row(FUNC_UNPACK, 1'b1,   33,   33, 161, 1'b1,  135168,  135168, 0);
    dir_rows[10] = row(FUNC_READ,   1'b1,    0,    0, 161, 1'b1,       0,       0, 2);
    dir_rows[11] = row(FUNC_READ,   1'b0,   -1,   -1, 255, 1'b1,       0,       0, 1);
    dir_rows[12] = row(FUNC_READ,   1'b0,    0,    0,   1, 1'b1,       0,       0, 1);
    dir_rows[13] = row(FUNC_UNPACK, 1'b0,   -1,    1,   0, 1'b0,       0,       0, 0);
    dir_rows[14] = row(FUNC_READ,   1'b0,    0,    0, 127, 1'b0,       0,       0, 0);
    dir_rows[15] = row(FUNC_UNPACK, 1'b1,  127,  127,  85, 1'b0,       0,       0, 0);
    dir_rows[16] = row(FUNC_READ,   1'b1,    0,    0, 255, 1'b0,       0,       0, 0);
    dir_rows[17] = row(FUNC_READ,   1'b1,    0,    0,   0, 1'b1,       0,       0, 0);
    dir_rows[18] = row(FUNC_UNPACK, 1'b0, -127,  127, 170, 1'b0,       0,       0, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);
    end

    // random phases, scale changed only while idle
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: phase_scale = '1;
        1: phase_scale = '0;
        2: phase_scale = scale_t'($urandom_range(0, 65535));
        3: phase_scale = SCALE_RESET;
        4: phase_scale = scale_t'($urandom_range(32768, 65535));
        default: phase_scale = scale_t'(1);
      endcase
      write_scale(phase_scale);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 50 == 0) begin
          send_no_idle = ($urandom_range(0, 2) == 0);
        end
        send_word(draw_word(), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
